### rtl/core/i2cs_pkg.sv
package i2cs_pkg;

	// byte store geometry
	localparam int STORE_DEPTH = 16;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SLOT_W      = 9;  // holds any slot or index up to the largest depth
	localparam int IDX_W       = 5;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BYTE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_ADDRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_LENGTH  = 2'd2;
	localparam logic [7:0]           ADDRESS_BYTE_RST     = 8'hD0;

	// operations
	localparam logic [1:0] OP_EVENT = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_START = 2'd3;

	// bus engine status codes
	localparam logic [7:0] ST_START     = 8'h08;
	localparam logic [7:0] ST_RESTART   = 8'h10;
	localparam logic [7:0] ST_TADDR_ACK = 8'h18;
	localparam logic [7:0] ST_TDATA_ACK = 8'h28;
	localparam logic [7:0] ST_RADDR_ACK = 8'h40;
	localparam logic [7:0] ST_RDATA_ACK = 8'h50;
	localparam logic [7:0] ST_RDATA_NAK = 8'h58;

	// transfer status
	localparam logic [1:0] STAT_BUSY = 2'd0;
	localparam logic [1:0] STAT_DONE = 2'd1;
	localparam logic [1:0] STAT_FAIL = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] status_code;
		logic [7:0] bus_data;
		logic [3:0] store_index;
		logic [7:0] host_data;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] tx_data;
		logic       tx_load;
		logic       start_bit;
		logic       stop_bit;
		logic       ack_bit;
		logic       bus_restart;
		logic [1:0] transfer_status;
		logic [7:0] read_data;
	} rsp_item_t;

endpackage

### rtl/core/i2cs_cmd_if.sv
interface i2cs_cmd_if;
	import i2cs_pkg::*;

	logic      valid;
	logic      ready;
	cmd_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

### rtl/core/i2cs_rsp_if.sv
interface i2cs_rsp_if;
	import i2cs_pkg::*;

	logic      valid;
	logic      ready;
	rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

### rtl/core/i2cs_ram.sv
module i2cs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/core/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer.
//
// cmd channel: one item per host operation or bus engine status event
// (operation, status_code, bus_data, store_index, host_data). rsp channel:
// exactly one item per cmd item, in order, with the byte to load into the
// bus data register, the start/stop/ack request levels, the restart pulse,
// the transfer status and the store byte for a host read.
// cfg port: cfg_we with cfg_index 0 address byte, 1 register address,
// 2 transfer length; index 3 is ignored. Write only while idle.
//
// An item passes stage 1 and then the output register before rsp valid;
// throughput is one item per cycle unless rsp.ready holds it off. Control
// levels and the byte index update in the accept cycle, while the byte
// store (a 16 x 8 RAM with registered read) supplies store bytes in the
// next cycle, in stage 1. The output register lets a new item in while
// a result waits on rsp.ready; with both stages full, cmd.ready drops
// until the receiver takes the result. Reset clears the levels, the index,
// the status and the config registers (address byte 0xD0). The store itself
// is not cleared; an unwritten slot reads as garbage.
module i2c_master_transfer_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [i2cs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2cs_pkg::CFG_W-1:0]     cfg_data,
	i2cs_cmd_if.sink                       cmd,
	i2cs_rsp_if.source                     rsp
);
	import i2cs_pkg::*;

	// stage 1 payload: everything but the RAM byte, plus how to use it
	typedef struct packed {
		logic [7:0] tx_fixed;
		logic       tx_load;
		logic       tx_from_ram;
		logic       rd_from_ram;
		logic       ram_ok;
		logic       start_bit;
		logic       stop_bit;
		logic       ack_bit;
		logic       bus_restart;
		logic [1:0] transfer_status;
	} s1_t;

	// config registers
	logic [7:0]       address_byte_q;
	logic [7:0]       register_address_q;
	logic [IDX_W-1:0] transfer_length_q;

	// sequencer state
	logic [IDX_W-1:0] byte_index_q;
	logic             start_q;
	logic             stop_q;
	logic             ack_q;
	logic [1:0]       status_q;

	// next-state values
	logic [IDX_W-1:0] byte_index_d;
	logic             start_d;
	logic             stop_d;
	logic             ack_d;
	logic [1:0]       status_d;

	// pipeline
	logic      valid_s1;
	s1_t       item_s1;
	s1_t       s1_d;
	logic      out_valid_q;
	rsp_item_t out_q;
	rsp_item_t out_d;

	logic advance;
	logic accept;

	// RAM access
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;
	logic [7:0]        ram_byte;

	logic [SLOT_W-1:0] idx_ext;
	logic [SLOT_W-1:0] slot_ext;
	logic              idx_ok;
	logic              slot_ok;
	cmd_item_t         c;

	// handshake: stage 1 moves on when the output register is free or drains
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign accept    = cmd.valid && cmd.ready;
	assign c         = cmd.item;

	// slot range checks: anything past the store is dropped / reads zero
	assign idx_ext  = SLOT_W'(byte_index_q);
	assign slot_ext = SLOT_W'(c.store_index);
	assign idx_ok   = idx_ext < SLOT_W'(STORE_DEPTH);
	assign slot_ok  = slot_ext < SLOT_W'(STORE_DEPTH);

	// decode one item
	always_comb begin
		byte_index_d = byte_index_q;
		start_d      = start_q;
		stop_d       = stop_q;
		ack_d        = ack_q;
		status_d     = status_q;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_waddr    = idx_ext[ADDR_W-1:0];
		ram_raddr    = idx_ext[ADDR_W-1:0];
		ram_wdata    = c.bus_data;
		s1_d         = '0;

		case (c.operation)
			OP_EVENT: begin
				case (c.status_code)
					ST_START, ST_RESTART: begin
						s1_d.tx_fixed = address_byte_q;
						s1_d.tx_load  = 1'b1;
						start_d       = 1'b0;
						byte_index_d  = '0;
					end
					ST_TADDR_ACK: begin
						s1_d.tx_fixed = register_address_q;
						s1_d.tx_load  = 1'b1;
					end
					ST_TDATA_ACK: begin
						if (byte_index_q < transfer_length_q) begin
							// store byte arrives from the RAM next cycle
							ram_re           = accept;
							s1_d.tx_load     = 1'b1;
							s1_d.tx_from_ram = 1'b1;
							s1_d.ram_ok      = idx_ok;
							byte_index_d     = byte_index_q + 5'd1;
						end else begin
							status_d = STAT_DONE;
							stop_d   = 1'b1;
						end
					end
					ST_RADDR_ACK: begin
						ack_d = (transfer_length_q != 5'd1);
					end
					ST_RDATA_ACK: begin
						if (byte_index_q < transfer_length_q) begin
							ram_we       = accept && idx_ok;
							byte_index_d = byte_index_q + 5'd1;
							ack_d        = 1'b1;
						end
						if (byte_index_d >= transfer_length_q) begin
							ack_d = 1'b0;
						end
					end
					ST_RDATA_NAK: begin
						// last byte: stored without advancing the index
						ram_we   = accept && idx_ok;
						stop_d   = 1'b1;
						ack_d    = 1'b1;
						status_d = STAT_DONE;
					end
					default: begin
						// NACKs, lost arbitration, unknown codes
						s1_d.bus_restart = 1'b1;
						start_d          = 1'b0;
						stop_d           = 1'b0;
						ack_d            = 1'b0;
						status_d         = STAT_FAIL;
					end
				endcase
			end
			OP_WRITE: begin
				ram_we    = accept && slot_ok;
				ram_waddr = slot_ext[ADDR_W-1:0];
				ram_wdata = c.host_data;
			end
			OP_READ: begin
				ram_re           = accept;
				ram_raddr        = slot_ext[ADDR_W-1:0];
				s1_d.rd_from_ram = 1'b1;
				s1_d.ram_ok      = slot_ok;
			end
			OP_START: begin
				status_d = STAT_BUSY;
				stop_d   = 1'b0;
				start_d  = 1'b1;
			end
			default: begin
			end
		endcase

		s1_d.start_bit       = start_d;
		s1_d.stop_bit        = stop_d;
		s1_d.ack_bit         = ack_d;
		s1_d.transfer_status = status_d;
	end

	i2cs_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_byte_q     <= ADDRESS_BYTE_RST;
			register_address_q <= '0;
			transfer_length_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ADDRESS_BYTE:     address_byte_q     <= cfg_data;
				CFG_REGISTER_ADDRESS: register_address_q <= cfg_data;
				CFG_TRANSFER_LENGTH:  transfer_length_q  <= cfg_data[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer state, updated as each item is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			start_q      <= 1'b0;
			stop_q       <= 1'b0;
			ack_q        <= 1'b0;
			status_q     <= STAT_BUSY;
		end else if (accept) begin
			byte_index_q <= byte_index_d;
			start_q      <= start_d;
			stop_q       <= stop_d;
			ack_q        <= ack_d;
			status_q     <= status_d;
		end
	end

	// stage 1; RAM read data lines up with it and holds while it stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= s1_d;
		end
	end

	// merge in the store byte
	assign ram_byte = item_s1.ram_ok ? ram_rdata : 8'd0;

	always_comb begin
		out_d.tx_data         = item_s1.tx_from_ram ? ram_byte : item_s1.tx_fixed;
		out_d.tx_load         = item_s1.tx_load;
		out_d.start_bit       = item_s1.start_bit;
		out_d.stop_bit        = item_s1.stop_bit;
		out_d.ack_bit         = item_s1.ack_bit;
		out_d.bus_restart     = item_s1.bus_restart;
		out_d.transfer_status = item_s1.transfer_status;
		out_d.read_data       = item_s1.rd_from_ram ? ram_byte : 8'd0;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.item  = out_q;

`ifndef SYNTHESIS
	// one item never both writes and reads the store
	a_ram_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store written and read by the same item");

	// sequencer state moves only on an accepted item
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(byte_index_q) && $stable(status_q))
		else $error("sequencer state changed without an item");

	// a stalled stage 1 keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stage 1 item lost while stalled");

	// a restart pulse always comes with a failed status
	a_restart_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.item.bus_restart |-> rsp.item.transfer_status == STAT_FAIL)
		else $error("restart without failure status");

	// no data byte offered unless it is to be loaded
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.item.tx_load |-> rsp.item.tx_data == 8'd0)
		else $error("tx_data nonzero without tx_load");
`endif
endmodule
